>>> rtl/pfcs_pkg.sv
// Shared types, codes and constants of the parallel flash command sequencer.
package pfcs_pkg;

    localparam int ADDR_W     = 19;
    localparam int DATA_W     = 8;
    localparam int WAIT_W     = 16;
    localparam int CMD_W      = 3;
    localparam int KIND_W     = 2;
    localparam int SEQ_W      = 2;
    localparam int STEP_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 48;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [CMD_W-1:0] CMD_READ         = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PROGRAM      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ_ID      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CHIP_ERASE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SECTOR_ERASE = 3'd4;

    localparam logic [KIND_W-1:0] OP_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] OP_READ  = 2'd1;
    localparam logic [KIND_W-1:0] OP_WAIT  = 2'd2;

    localparam logic [SEQ_W-1:0] SEQ_READ    = 2'd0;
    localparam logic [SEQ_W-1:0] SEQ_PROGRAM = 2'd1;
    localparam logic [SEQ_W-1:0] SEQ_READ_ID = 2'd2;
    localparam logic [SEQ_W-1:0] SEQ_ERASE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_ERASE_WAIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_ERASE_WAIT = 2'd1;

    localparam logic [WAIT_W-1:0] CHIP_ERASE_WAIT_RESET   = 16'd1000;
    localparam logic [WAIT_W-1:0] SECTOR_ERASE_WAIT_RESET = 16'd100;

    localparam logic [ADDR_W-1:0] UNLOCK_ADDR_A = 19'h05555;
    localparam logic [ADDR_W-1:0] UNLOCK_ADDR_B = 19'h02AAA;

    localparam logic [DATA_W-1:0] BYTE_UNLOCK_1     = 8'hAA;
    localparam logic [DATA_W-1:0] BYTE_UNLOCK_2     = 8'h55;
    localparam logic [DATA_W-1:0] BYTE_PROGRAM      = 8'hA0;
    localparam logic [DATA_W-1:0] BYTE_ID_ENTRY     = 8'h90;
    localparam logic [DATA_W-1:0] BYTE_ID_EXIT      = 8'hF0;
    localparam logic [DATA_W-1:0] BYTE_ERASE_SETUP  = 8'h80;
    localparam logic [DATA_W-1:0] BYTE_CHIP_ERASE   = 8'h10;
    localparam logic [DATA_W-1:0] BYTE_SECTOR_ERASE = 8'h30;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [WAIT_W-1:0] wait_ms;
    } desc_t;

endpackage

>>> rtl/parallel_flash_command_sequencer_core.sv
// Top level of the parallel NOR flash command sequencer.
// Path: a taken command is written into the queue, then its first beat is registered at the output.
// Throughput: one operation beat per cycle while m_tready is high; a command yields 1, 4 or 7
// beats, set by the back-end step counter; an unknown command is taken and dropped.
// Reset: wait registers to 1000 and 100 ms, queue emptied, output beat invalid.
module parallel_flash_command_sequencer_core #(
    parameter int QUEUE_DEPTH = pfcs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pfcs_pkg::CMD_W-1:0]     s_tuser,   // cmd
    input  logic [pfcs_pkg::S_TDATA_W-1:0] s_tdata,   // target_address, write_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pfcs_pkg::KIND_W-1:0]    m_tuser,   // op_kind
    output logic [pfcs_pkg::M_TDATA_W-1:0] m_tdata,   // bus_address, bus_data, wait_ms
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [pfcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfcs_pkg::WAIT_W-1:0]    cfg_data
);
    import pfcs_pkg::*;

    logic  q_full;
    logic  q_push;
    desc_t q_desc;
    logic  q_pop;
    desc_t head_desc;
    logic  head_valid;

    pfcs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_desc    (q_desc)
    );

    pfcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_desc  (q_desc),
        .pop        (q_pop),
        .head_desc  (head_desc),
        .head_valid (head_valid),
        .full       (q_full)
    );

    pfcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_desc  (head_desc),
        .head_valid (head_valid),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

>>> rtl/pfcs_front.sv
// Command intake: configuration registers and command classification.
module pfcs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pfcs_pkg::CMD_W-1:0]    s_tuser,    // cmd
    input  logic [pfcs_pkg::S_TDATA_W-1:0] s_tdata,   // target_address, write_byte
    input  logic                          cfg_we,
    input  logic [pfcs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pfcs_pkg::WAIT_W-1:0]   cfg_data,
    input  logic                          q_full,
    output logic                          q_push,
    output pfcs_pkg::desc_t               q_desc
);
    import pfcs_pkg::*;

    logic [WAIT_W-1:0] chip_wait_reg;
    logic [WAIT_W-1:0] sector_wait_reg;
    logic [ADDR_W-1:0] in_addr;
    logic [DATA_W-1:0] in_byte;
    logic              cmd_known;

    assign in_addr = s_tdata[ADDR_W-1:0];
    assign in_byte = s_tdata[ADDR_W+DATA_W-1:ADDR_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chip_wait_reg   <= CHIP_ERASE_WAIT_RESET;
            sector_wait_reg <= SECTOR_ERASE_WAIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_CHIP_ERASE_WAIT)
            begin
                chip_wait_reg <= cfg_data;
            end
            else if (cfg_index == CFG_SECTOR_ERASE_WAIT)
            begin
                sector_wait_reg <= cfg_data;
            end
        end
    end

    // chip erase is a sector-style erase whose final write hits the unlock address
    always_comb
    begin
        cmd_known      = 1'b1;
        q_desc.seq     = SEQ_READ;
        q_desc.addr    = in_addr;
        q_desc.data    = '0;
        q_desc.wait_ms = '0;
        case (s_tuser)
            CMD_READ:
            begin
                q_desc.seq = SEQ_READ;
            end
            CMD_PROGRAM:
            begin
                q_desc.seq  = SEQ_PROGRAM;
                q_desc.data = in_byte;
            end
            CMD_READ_ID:
            begin
                q_desc.seq = SEQ_READ_ID;
            end
            CMD_CHIP_ERASE:
            begin
                q_desc.seq     = SEQ_ERASE;
                q_desc.addr    = UNLOCK_ADDR_A;
                q_desc.data    = BYTE_CHIP_ERASE;
                q_desc.wait_ms = chip_wait_reg;
            end
            CMD_SECTOR_ERASE:
            begin
                q_desc.seq     = SEQ_ERASE;
                q_desc.data    = BYTE_SECTOR_ERASE;
                q_desc.wait_ms = sector_wait_reg;
            end
            default:
            begin
                cmd_known = 1'b0;
            end
        endcase
    end

    // unknown commands are taken and dropped
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && cmd_known;

endmodule

>>> rtl/pfcs_queue.sv
// Short descriptor queue between command intake and the bus sequencer.
module pfcs_queue #(
    parameter int DEPTH = pfcs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pfcs_pkg::desc_t push_desc,
    input  logic            pop,
    output pfcs_pkg::desc_t head_desc,
    output logic            head_valid,
    output logic            full
);
    import pfcs_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    desc_t          mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CW'(DEPTH));
    assign head_desc  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CW'(DEPTH)))
        else $error("descriptor pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("descriptor popped from empty queue");

endmodule

>>> rtl/pfcs_back.sv
// Bus sequencer: steps through the operation run of each queued command.
module pfcs_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pfcs_pkg::desc_t                head_desc,
    input  logic                           head_valid,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pfcs_pkg::KIND_W-1:0]    m_tuser,   // op_kind
    output logic [pfcs_pkg::M_TDATA_W-1:0] m_tdata,   // bus_address, bus_data, wait_ms
    output logic                           m_tlast
);
    import pfcs_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [WAIT_W-1:0] wait_ms;
        logic              last;
    } op_t;

    desc_t             desc_reg;
    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    op_t               out_reg;
    desc_t             active;
    logic              have;
    logic              adv;
    op_t               op;

    function automatic op_t wr(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] d);
        op_t o;
        o.kind    = OP_WRITE;
        o.addr    = a;
        o.data    = d;
        o.wait_ms = '0;
        o.last    = 1'b0;
        return o;
    endfunction

    function automatic op_t rd(input logic [ADDR_W-1:0] a);
        op_t o;
        o.kind    = OP_READ;
        o.addr    = a;
        o.data    = '0;
        o.wait_ms = '0;
        o.last    = 1'b0;
        return o;
    endfunction

    assign active = busy_reg ? desc_reg : head_desc;
    assign have   = busy_reg || head_valid;
    assign adv    = have && (!out_valid_reg || m_tready);
    assign pop    = adv && !busy_reg;

    always_comb
    begin
        op = wr(UNLOCK_ADDR_A, BYTE_UNLOCK_1);
        case (active.seq)
            SEQ_READ:
            begin
                op      = rd(active.addr);
                op.last = 1'b1;
            end
            SEQ_PROGRAM:
            begin
                case (step_reg)
                    3'd0:    op = wr(UNLOCK_ADDR_A, BYTE_UNLOCK_1);
                    3'd1:    op = wr(UNLOCK_ADDR_B, BYTE_UNLOCK_2);
                    3'd2:    op = wr(UNLOCK_ADDR_A, BYTE_PROGRAM);
                    default:
                    begin
                        op      = wr(active.addr, active.data);
                        op.last = 1'b1;
                    end
                endcase
            end
            SEQ_READ_ID:
            begin
                case (step_reg)
                    3'd0:    op = wr(UNLOCK_ADDR_A, BYTE_UNLOCK_1);
                    3'd1:    op = wr(UNLOCK_ADDR_B, BYTE_UNLOCK_2);
                    3'd2:    op = wr(UNLOCK_ADDR_A, BYTE_ID_ENTRY);
                    3'd3:    op = rd(active.addr);
                    3'd4:    op = wr(UNLOCK_ADDR_A, BYTE_UNLOCK_1);
                    3'd5:    op = wr(UNLOCK_ADDR_B, BYTE_UNLOCK_2);
                    default:
                    begin
                        op      = wr(UNLOCK_ADDR_A, BYTE_ID_EXIT);
                        op.last = 1'b1;
                    end
                endcase
            end
            SEQ_ERASE:
            begin
                case (step_reg)
                    3'd0:    op = wr(UNLOCK_ADDR_A, BYTE_UNLOCK_1);
                    3'd1:    op = wr(UNLOCK_ADDR_B, BYTE_UNLOCK_2);
                    3'd2:    op = wr(UNLOCK_ADDR_A, BYTE_ERASE_SETUP);
                    3'd3:    op = wr(UNLOCK_ADDR_A, BYTE_UNLOCK_1);
                    3'd4:    op = wr(UNLOCK_ADDR_B, BYTE_UNLOCK_2);
                    3'd5:    op = wr(active.addr, active.data);
                    default:
                    begin
                        op.kind    = OP_WAIT;
                        op.addr    = '0;
                        op.data    = '0;
                        op.wait_ms = active.wait_ms;
                        op.last    = 1'b1;
                    end
                endcase
            end
            default:
            begin
                op = wr(UNLOCK_ADDR_A, BYTE_UNLOCK_1);
            end
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            out_valid_next = 1'b1;
            if (op.last)
            begin
                busy_next = 1'b0;
                step_next = '0;
            end
            else
            begin
                busy_next = 1'b1;
                step_next = step_reg + 1'b1;
            end
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            desc_reg <= head_desc;
        end
        if (adv)
        begin
            out_reg <= op;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {{(M_TDATA_W - ADDR_W - DATA_W - WAIT_W){1'b0}},
                       out_reg.wait_ms, out_reg.data, out_reg.addr};

    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (step_reg != '0))
        else $error("sequencer busy at step zero");

    a_wait_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.kind == OP_WAIT)) |-> out_reg.last)
        else $error("wait beat not last of run");

endmodule
